// ===== hw/rtl/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fxalu_pkg: shared definitions for the fixed-point ALU
// Operation codes and default word and fraction widths.
// ----------------------------------------------------------------------------
package fxalu_pkg;

	// Default format is Q24.8 in a 32-bit word.
	localparam int unsigned FRAC_BITS_DEF = 8;
	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned FUNC_BITS     = 4;

	// Operation codes carried in the input tuser.
	typedef enum logic [FUNC_BITS-1:0] {
		FN_ADD      = 4'd0,
		FN_SUB      = 4'd1,
		FN_MUL      = 4'd2,
		FN_DIV      = 4'd3,
		FN_LT       = 4'd4,
		FN_GT       = 4'd5,
		FN_LE       = 4'd6,
		FN_GE       = 4'd7,
		FN_EQ       = 4'd8,
		FN_NE       = 4'd9,
		FN_MIN      = 4'd10,
		FN_MAX      = 4'd11,
		FN_INC      = 4'd12,
		FN_FROM_INT = 4'd13,
		FN_TO_INT   = 4'd14
	} func_t;

endpackage

// ===== hw/rtl/fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point ALU, pipelined
// Every operation passes through every stage; the default format is Q24.8.
// Throughput is one beat per cycle unless the output stalls; the depth is set by
// the divider, which resolves one quotient bit per pipeline stage.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
	parameter int unsigned FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF,
	parameter int unsigned WORD_BITS = fxalu_pkg::WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Input stream.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata: operand_a, operand_b (then zero padding).
	input  logic [((2*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// tuser: func.
	input  logic [fxalu_pkg::FUNC_BITS-1:0]       s_axis_tuser,
	// Output stream.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// tdata: result_value, compare_true, divide_by_zero (then zero padding).
	output logic [((WORD_BITS+2+7)/8)*8-1:0]      m_axis_tdata
);

	localparam int unsigned W          = WORD_BITS;
	localparam int unsigned F          = FRAC_BITS;
	localparam int unsigned N          = W + F;          // dividend bits
	localparam int unsigned NS         = N + 2;          // total stages
	localparam int unsigned H          = (W + 1) / 2;    // multiplier split
	localparam int unsigned MUL_STAGE  = 5;              // product lands here
	localparam int unsigned OUT_DATA_W = ((W + 2 + 7) / 8) * 8;

	// Stage registers; index k is pipeline stage k.
	logic                     vld_s  [1:NS];
	fxalu_pkg::func_t         func_s [1:NS-1];
	logic [W-1:0]             res_s  [1:NS-1];
	logic                     cmp_s  [1:NS-1];
	logic                     dbz_s  [1:NS-1];
	logic                     negq_s [1:NS-1];
	logic [W-1:0]             dvs_s  [1:NS-1];
	logic [W-1:0]             rem_s  [1:NS-1];
	logic [N-1:0]             qd_s   [1:NS-1];

	// Output stage.
	logic [W-1:0]             out_res_s;
	logic                     out_cmp_s;
	logic                     out_dbz_s;

	// Stage k may load when it is empty or its content moves on.
	logic [1:NS]              go;

	assign go[NS] = !vld_s[NS] || m_axis_tready;

	for (genvar k = 1; k < NS; k++) begin : g_go
		assign go[k] = !vld_s[k] || go[k+1];
	end

	assign s_axis_tready = go[1];

	// ------------------------------------------------------------------
	// Stage 1: decode, operations computed in this stage, operand magnitudes.
	// ------------------------------------------------------------------
	fxalu_pkg::func_t         func_in;
	logic signed [W-1:0]      a_in;
	logic signed [W-1:0]      b_in;
	logic [W-1:0]             a_u;
	logic [W-1:0]             b_u;
	logic [W-1:0]             ma_c;
	logic [W-1:0]             mb_c;
	logic                     lt_c;
	logic                     gt_c;
	logic                     eq_c;
	logic [W-1:0]             res_c;
	logic                     cmp_c;

	assign func_in = fxalu_pkg::func_t'(s_axis_tuser);
	assign a_u     = s_axis_tdata[W-1:0];
	assign b_u     = s_axis_tdata[2*W-1:W];
	assign a_in    = $signed(a_u);
	assign b_in    = $signed(b_u);
	assign ma_c    = a_u[W-1] ? (~a_u + {{(W-1){1'b0}}, 1'b1}) : a_u;
	assign mb_c    = b_u[W-1] ? (~b_u + {{(W-1){1'b0}}, 1'b1}) : b_u;
	assign lt_c    = a_in < b_in;
	assign gt_c    = b_in < a_in;
	assign eq_c    = a_u == b_u;

	always_comb begin
		res_c = '0;
		cmp_c = 1'b0;
		case (func_in)
			fxalu_pkg::FN_ADD:      res_c = a_u + b_u;
			fxalu_pkg::FN_SUB:      res_c = a_u - b_u;
			fxalu_pkg::FN_LT:       cmp_c = lt_c;
			fxalu_pkg::FN_GT:       cmp_c = gt_c;
			fxalu_pkg::FN_LE:       cmp_c = !gt_c;
			fxalu_pkg::FN_GE:       cmp_c = !lt_c;
			fxalu_pkg::FN_EQ:       cmp_c = eq_c;
			fxalu_pkg::FN_NE:       cmp_c = !eq_c;
			fxalu_pkg::FN_MIN:      res_c = lt_c ? a_u : b_u;
			fxalu_pkg::FN_MAX:      res_c = gt_c ? a_u : b_u;
			fxalu_pkg::FN_INC:      res_c = a_u + {{(W-1){1'b0}}, 1'b1};
			fxalu_pkg::FN_FROM_INT: res_c = a_u << F;
			fxalu_pkg::FN_TO_INT:   res_c = $unsigned(a_in >>> F);
			default:                res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (go[1]) begin
			vld_s[1] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (go[1]) begin
			func_s[1] <= func_in;
			res_s[1]  <= res_c;
			cmp_s[1]  <= cmp_c;
			dbz_s[1]  <= (func_in == fxalu_pkg::FN_DIV) && (b_u == '0);
			negq_s[1] <= a_u[W-1] ^ b_u[W-1];
			dvs_s[1]  <= mb_c;
			rem_s[1]  <= '0;
			qd_s[1]   <= {ma_c, {F{1'b0}}};
		end
	end

	// ------------------------------------------------------------------
	// Multiplier on operand magnitudes: partial products, two adds, then
	// sign and scaling. It runs beside the first divider stages.
	// ------------------------------------------------------------------
	logic [2*H-1:0]           pp_ll_s2;
	logic [W-1:0]             pp_lh_s2;
	logic [W-1:0]             pp_hl_s2;
	logic [2*(W-H)-1:0]       pp_hh_s2;
	logic [W:0]               mid_s3;
	logic [2*W-1:0]           cross_s3;
	logic [2*W-1:0]           prod_s4;
	logic [W-1:0]             ma_s1;
	logic signed [2*W-1:0]    pn_c;
	logic signed [2*W-1:0]    psh_c;
	logic [W-1:0]             mul_res_c;

	assign ma_s1 = qd_s[1][N-1:F];

	always_ff @(posedge clk) begin
		if (go[2]) begin
			pp_ll_s2 <= ma_s1[H-1:0] * dvs_s[1][H-1:0];
			pp_lh_s2 <= ma_s1[H-1:0] * dvs_s[1][W-1:H];
			pp_hl_s2 <= ma_s1[W-1:H] * dvs_s[1][H-1:0];
			pp_hh_s2 <= ma_s1[W-1:H] * dvs_s[1][W-1:H];
		end
		if (go[3]) begin
			mid_s3   <= {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
			cross_s3 <= {pp_hh_s2, pp_ll_s2};
		end
		if (go[4]) begin
			prod_s4 <= cross_s3 + ((2*W)'(mid_s3) << H);
		end
	end

	assign pn_c      = negq_s[4] ? $signed(~prod_s4 + {{(2*W-1){1'b0}}, 1'b1})
	                             : $signed(prod_s4);
	assign psh_c     = pn_c >>> F;
	assign mul_res_c = psh_c[W-1:0];

	// ------------------------------------------------------------------
	// Divider: one restoring step per stage. qd shifts dividend bits out
	// of the top while quotient bits enter at the bottom.
	// ------------------------------------------------------------------
	for (genvar k = 2; k <= N + 1; k++) begin : g_div
		logic [W:0] trial;
		logic [W:0] diff;
		logic       take;

		assign trial = {rem_s[k-1], qd_s[k-1][N-1]};
		assign diff  = trial - {1'b0, dvs_s[k-1]};
		assign take  = trial >= {1'b0, dvs_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (go[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (go[k]) begin
				func_s[k] <= func_s[k-1];
				cmp_s[k]  <= cmp_s[k-1];
				dbz_s[k]  <= dbz_s[k-1];
				negq_s[k] <= negq_s[k-1];
				dvs_s[k]  <= dvs_s[k-1];
				rem_s[k]  <= take ? diff[W-1:0] : trial[W-1:0];
				qd_s[k]   <= {qd_s[k-1][N-2:0], take};
				if ((k == MUL_STAGE) && (func_s[k-1] == fxalu_pkg::FN_MUL)) begin
					res_s[k] <= mul_res_c;
				end else begin
					res_s[k] <= res_s[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: quotient sign and final result selection.
	// ------------------------------------------------------------------
	logic [W-1:0] quo_c;
	logic [W-1:0] quo_sgn_c;

	assign quo_c     = qd_s[NS-1][W-1:0];
	assign quo_sgn_c = negq_s[NS-1] ? (~quo_c + {{(W-1){1'b0}}, 1'b1}) : quo_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NS] <= 1'b0;
		end else if (go[NS]) begin
			vld_s[NS] <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (go[NS]) begin
			out_cmp_s <= cmp_s[NS-1];
			out_dbz_s <= dbz_s[NS-1];
			if (func_s[NS-1] == fxalu_pkg::FN_DIV) begin
				out_res_s <= dbz_s[NS-1] ? '0 : quo_sgn_c;
			end else begin
				out_res_s <= res_s[NS-1];
			end
		end
	end

	assign m_axis_tvalid = vld_s[NS];
	assign m_axis_tdata  = OUT_DATA_W'({out_dbz_s, out_cmp_s, out_res_s});

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// Input can only be held off when every stage is full and output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while the pipeline has a free stage");

	// A divide by zero is never also a comparison outcome.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_dbz_s && out_cmp_s))
		else $error("divide-by-zero and compare flags both set");

	// A divide by zero always returns zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_dbz_s) |-> (out_res_s == '0))
		else $error("divide by zero returned a nonzero result");

	// A beat entering stage 1 with an empty stage 2 moves on next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && !vld_s[2]) |=> vld_s[2])
		else $error("beat lost or held with a free next stage");

endmodule

// ===== verif/fxalu_checker.sv =====
// ----------------------------------------------------------------------------
// fxalu_checker: result predictor and scoreboard for the fixed-point ALU
// Watches both streams. Every accepted input beat is turned into the result
// the ALU must produce. Every output beat is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fxalu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// tdata: operand_a, operand_b.
	input  logic [63:0] s_axis_tdata,
	// tuser: func.
	input  logic [3:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: result_value, compare_true, divide_by_zero, zero padding.
	input  logic [39:0] m_axis_tdata,
	output int          mismatch_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB  = fxalu_pkg::WORD_BITS_DEF;
	localparam int FB  = fxalu_pkg::FRAC_BITS_DEF;
	localparam int OPW = fxalu_pkg::FUNC_BITS;

	typedef struct {
		logic [OPW-1:0]       op;
		logic signed [WB-1:0] value;
		logic                 cmp;
		logic                 dbz;
	} alu_result_t;

	alu_result_t alu_results_q[$];

	initial mismatch_count = 0;
	initial outstanding = 0;

	// Computes the result of one operation on raw fixed-point words.
	function automatic alu_result_t fx_alu_result(logic [OPW-1:0] op,
			logic signed [WB-1:0] a, logic signed [WB-1:0] b);
		alu_result_t r;
		longint wide;
		r.op = op;
		r.value = '0;
		r.cmp = 1'b0;
		r.dbz = 1'b0;
		case (op)
			fxalu_pkg::FN_ADD: r.value = a + b;
			fxalu_pkg::FN_SUB: r.value = a - b;
			fxalu_pkg::FN_MUL: begin
				// Full product, then drop the fraction bits with an arithmetic shift.
				wide = longint'(a) * longint'(b);
				r.value = WB'(wide >>> FB);
			end
			fxalu_pkg::FN_DIV: begin
				if (b == 0) begin
					r.dbz = 1'b1;
				end else begin
					// Integer division truncates toward zero; overflow keeps low bits.
					wide = (longint'(a) <<< FB) / longint'(b);
					r.value = WB'(wide);
				end
			end
			fxalu_pkg::FN_LT: r.cmp = a < b;
			fxalu_pkg::FN_GT: r.cmp = b < a;
			fxalu_pkg::FN_LE: r.cmp = !(b < a);
			fxalu_pkg::FN_GE: r.cmp = !(a < b);
			fxalu_pkg::FN_EQ: r.cmp = a == b;
			fxalu_pkg::FN_NE: r.cmp = a != b;
			fxalu_pkg::FN_MIN: r.value = (a < b) ? a : b;
			fxalu_pkg::FN_MAX: r.value = (b < a) ? a : b;
			fxalu_pkg::FN_INC: r.value = a + 1;
			fxalu_pkg::FN_FROM_INT: r.value = a <<< FB;
			fxalu_pkg::FN_TO_INT: r.value = a >>> FB;
			default: ;
		endcase
		return r;
	endfunction

	// Counts a failure; only the first few are printed.
	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	// Predict on input beats, compare on output beats.
	always @(posedge clk) begin : scoreboard
		alu_result_t want;
		logic signed [WB-1:0] got_value;
		logic got_cmp, got_dbz;
		got_value = m_axis_tdata[WB-1:0];
		got_cmp = m_axis_tdata[WB];
		got_dbz = m_axis_tdata[WB+1];
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				alu_results_q.push_back(fx_alu_result(s_axis_tuser,
					s_axis_tdata[WB-1:0], s_axis_tdata[2*WB-1:WB]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (alu_results_q.size() == 0) begin
					flag_error($sformatf("unexpected output beat, value %0d", got_value));
				end else begin
					want = alu_results_q.pop_front();
					if (got_value !== want.value) begin
						flag_error($sformatf("op %0d result_value: expected %0d, got %0d",
							want.op, want.value, got_value));
					end
					if (got_cmp !== want.cmp) begin
						flag_error($sformatf("op %0d compare_true: expected %0b, got %0b",
							want.op, want.cmp, got_cmp));
					end
					if (got_dbz !== want.dbz) begin
						flag_error($sformatf("op %0d divide_by_zero: expected %0b, got %0b",
							want.op, want.dbz, got_dbz));
					end
				end
			end
		end
		outstanding <= alu_results_q.size();
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the fixed-point ALU
// Sends a directed set of corner operations, then phases of random beats with and
// without random source gaps and sink stalls, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB  = fxalu_pkg::WORD_BITS_DEF;
	localparam int FB  = fxalu_pkg::FRAC_BITS_DEF;
	localparam int OPW = fxalu_pkg::FUNC_BITS;
	// Code 15 is not an operation; the ALU must return all zeros for it.
	localparam logic [OPW-1:0] FN_RESERVED = 4'd15;
	localparam int SETTLE_CYCLES = WB + FB + 20;
	localparam logic [WB-1:0] MAX_WORD = 32'h7fff_ffff;
	localparam logic [WB-1:0] MIN_WORD = 32'h8000_0000;
	localparam logic [WB-1:0] ONES = 32'hffff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	int errors;
	int outstanding;
	// When set, that side runs with no gaps or stalls.
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;

	always #5 clk = ~clk;

	fixed_point_alu dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	fxalu_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (errors),
		.outstanding    (outstanding)
	);

	// Sends one operation beat after a random gap, or none when src_steady is set, and waits for its acceptance.
	task automatic send_op(logic [OPW-1:0] op, logic [WB-1:0] a, logic [WB-1:0] b);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Operand mix: extremes, small raw values, whole numbers and full-range words.
	function automatic logic [WB-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return MIN_WORD;
					1: return MAX_WORD;
					2: return '0;
					3: return ONES;
					default: return 1;
				endcase
			end
			1: return $urandom_range(0, 1023) - 512;
			2: return ($urandom_range(0, 255) - 128) << FB;
			default: return $urandom;
		endcase
	endfunction

	// Sink side: a random stall before each beat, none in steady phases.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [OPW-1:0] op;
		logic [WB-1:0] a, b;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases: wraparound, rounding direction, divide by zero, equal operands.
		send_op(fxalu_pkg::FN_ADD, MAX_WORD, 32'd1);
		send_op(fxalu_pkg::FN_SUB, MIN_WORD, 32'd1);
		send_op(fxalu_pkg::FN_MUL, MAX_WORD, MAX_WORD);
		send_op(fxalu_pkg::FN_MUL, MIN_WORD, MIN_WORD);
		send_op(fxalu_pkg::FN_MUL, ONES, 32'd1);
		send_op(fxalu_pkg::FN_MUL, 32'h0000_0180, 32'hffff_fe00);
		send_op(fxalu_pkg::FN_DIV, 32'h0000_0100, 32'd0);
		send_op(fxalu_pkg::FN_DIV, MIN_WORD, 32'd1);
		send_op(fxalu_pkg::FN_DIV, MIN_WORD, ONES);
		send_op(fxalu_pkg::FN_DIV, 32'd7, 32'hffff_fffe);
		send_op(fxalu_pkg::FN_LT, MIN_WORD, MAX_WORD);
		send_op(fxalu_pkg::FN_GT, MIN_WORD, MAX_WORD);
		send_op(fxalu_pkg::FN_LE, 32'd5, 32'd5);
		send_op(fxalu_pkg::FN_GE, MIN_WORD, MAX_WORD);
		send_op(fxalu_pkg::FN_EQ, ONES, ONES);
		send_op(fxalu_pkg::FN_NE, 32'd0, MIN_WORD);
		send_op(fxalu_pkg::FN_MIN, 32'h0000_0100, 32'h0000_0100);
		send_op(fxalu_pkg::FN_MIN, ONES, 32'd1);
		send_op(fxalu_pkg::FN_MAX, MIN_WORD, MAX_WORD);
		send_op(fxalu_pkg::FN_INC, MAX_WORD, ONES);
		send_op(fxalu_pkg::FN_FROM_INT, 32'h0100_0000, MAX_WORD);
		send_op(fxalu_pkg::FN_FROM_INT, ONES, 32'd0);
		send_op(fxalu_pkg::FN_TO_INT, ONES, 32'd0);
		send_op(fxalu_pkg::FN_TO_INT, MIN_WORD, MAX_WORD);
		send_op(FN_RESERVED, MAX_WORD, MAX_WORD);
		drain();

		// Random phases, each with its own mix of gaps and stalls, drained at the end.
		for (int phase = 0; phase < 4; phase++) begin
			src_steady = (phase == 1) || (phase == 2);
			sink_steady = (phase == 1) || (phase == 3);
			for (int n = 0; n < 120; n++) begin
				op = ($urandom_range(0, 31) == 0) ? FN_RESERVED
				                                  : OPW'($urandom_range(0, 14));
				a = rand_word();
				b = rand_word();
				if (op == fxalu_pkg::FN_DIV && $urandom_range(0, 7) == 0) begin
					b = '0;
				end
				send_op(op, a, b);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== fixed_point_alu.f =====
hw/rtl/fxalu_pkg.sv
hw/rtl/fixed_point_alu.sv
verif/fxalu_checker.sv
verif/tb.sv
